// ===== rtl/core/fdm_pkg.sv =====
// Shared constants, register indexes and sine table helpers for the drive mixer.
`timescale 1ns / 1ps

package fdm_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_SINE_TABLE_BITS = 10;
    localparam int DEFAULT_SAMPLE_WIDTH    = 16;

    // Fixed field and register widths.
    localparam int HEADING_W   = 16;
    localparam int DEADBAND_W  = 15;
    localparam int GAIN_W      = 16;
    localparam int SINE_W      = 17;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // Fraction bits: gains are Q4.12, sine values Q1.15.
    localparam int GAIN_FRAC   = 12;
    localparam int SINE_FRAC   = 15;
    localparam int FIELD_SHIFT = GAIN_FRAC + SINE_FRAC;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_XY      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_ROT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIELD_SPEED_GAIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_XY_GAIN     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RAW_ROT_GAIN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_ROT_GAIN    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FIELD_ROT_GAIN   = 3'd6;

    // Register values after reset.
    localparam logic [DEADBAND_W-1:0] RST_DEADBAND_XY      = 15'd6554;
    localparam logic [DEADBAND_W-1:0] RST_DEADBAND_ROT     = 15'd16384;
    localparam logic [GAIN_W-1:0]     RST_FIELD_SPEED_GAIN = 16'd3072;
    localparam logic [GAIN_W-1:0]     RST_SLOW_XY_GAIN     = 16'd2048;
    localparam logic [GAIN_W-1:0]     RST_RAW_ROT_GAIN     = 16'd8192;
    localparam logic [GAIN_W-1:0]     RST_SLOW_ROT_GAIN    = 16'd4096;
    localparam logic [GAIN_W-1:0]     RST_FIELD_ROT_GAIN   = 16'd6144;

    // Pi/2 in Q30 and one in Q30, for building the table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Sine of k quarter-steps in Q1.15, evaluated with an integer Taylor
    // series up to the eleventh power. Only used to build the constant table.
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] k,
                                                       input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (k * HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[SINE_W-1:0];
    endfunction

    // One entry of the full-turn table with 2^bits entries.
    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned i,
                                                            input int unsigned bits);
        logic [63:0] quarter;
        logic [63:0] r;
        logic [1:0]  q;
        logic signed [SINE_W-1:0] v;
        quarter = 64'd1 << (bits - 2);
        r       = 64'(i) & (quarter - 64'd1);
        q       = 2'((i >> (bits - 2)) & 3);
        unique case (q)
            2'd0:    v = $signed(quarter_sine(r, bits));
            2'd1:    v = $signed(quarter_sine(quarter - r, bits));
            2'd2:    v = -$signed(quarter_sine(r, bits));
            default: v = -$signed(quarter_sine(quarter - r, bits));
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/field_oriented_drive_mixer.sv =====
// Field-oriented holonomic drive mixer: deadband, heading rotation and gain pipeline.
`timescale 1ns / 1ps

// Usage
// The slave stream (s_tvalid, s_tready, s_tdata) carries one joystick sample per
// transaction: three axes, the robot heading and three buttons. The master stream
// (m_tvalid, m_tready, m_tdata) returns one transaction per sample with the three
// motor commands and the heading-reset flag, in the same order as the samples.
// Gains and deadbands are written through cfg_we, cfg_addr and cfg_wdata; they
// should only be changed while no sample is in flight.
// A sample accepted on the slave stream stands on m_tdata once it has passed the
// stage registers, and its result transaction completes when m_tready is high. The
// block is a five-stage pipeline (table read and deadband, products, sums and gain
// rounding, split field-gain products, final add and saturation) and takes one
// sample every cycle while s_tready is high. The widest arithmetic, the field gain
// on the rotated vector, is split into two partial products so no multiplier
// exceeds about 17 by 17 bits.
// Reset clears every stage valid bit and loads the configuration registers with
// their default values; the sine table is a constant ROM and needs no fill.
// When the receiver holds m_tready low, bubbles in the pipeline are squeezed
// out first and s_tready only falls once every stage holds a sample; nothing
// is dropped or duplicated.
module field_oriented_drive_mixer
    import fdm_pkg::*;
#(
    parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS,
    parameter int SAMPLE_WIDTH    = DEFAULT_SAMPLE_WIDTH
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    // Configuration write port.
    input  logic                                         cfg_we,
    input  logic [CFG_ADDR_W-1:0]                        cfg_addr,
    input  logic [CFG_DATA_W-1:0]                        cfg_wdata,
    // Sample stream.
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // s_tdata, from bit 0: stick_x, stick_y, stick_twist, heading,
    // button_raw, button_slow, button_zero_heading, zero padding.
    input  logic [((3*SAMPLE_WIDTH+HEADING_W+3+7)/8)*8-1:0] s_tdata,
    // Command stream.
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // m_tdata, from bit 0: drive_x, drive_y, drive_rot, zero_heading, zero padding.
    output logic [((3*SAMPLE_WIDTH+1+7)/8)*8-1:0]        m_tdata
);

    localparam int SW         = SAMPLE_WIDTH;
    localparam int TB         = SINE_TABLE_BITS;
    localparam int TABLE_SIZE = 1 << TB;
    localparam int OUT_W      = ((3*SW+1+7)/8)*8;
    localparam int NSTAGE     = 5;
    localparam int HEAD_HALF  = 1 << (15 - TB);

    // Product and sum widths.
    localparam int PROD_W = SW + SINE_W;          // stick times sine
    localparam int PX_W   = PROD_W + 1;           // rotated component
    localparam int LO_W   = (PX_W + 1) / 2;       // low split of rotated value
    localparam int HI_W   = PX_W - LO_W;          // high split, signed
    localparam int PL_W   = LO_W + GAIN_W + 1;    // low partial product plus rounding
    localparam int PH_W   = HI_W + GAIN_W + 1;    // high partial product
    localparam int FULL_W = PX_W + GAIN_W + 1;    // whole field product
    localparam int FR_W   = FULL_W - FIELD_SHIFT; // field product after rounding
    localparam int GP_W   = SW + GAIN_W + 1;      // deadbanded value times gain
    localparam int GR_W   = GP_W - GAIN_FRAC;     // gain product after rounding

    localparam logic [TB-1:0]     QUARTER_IDX = TB'(TABLE_SIZE / 4);
    localparam logic [PL_W-1:0]   FIELD_HALF  = PL_W'(1) << (FIELD_SHIFT - 1);
    localparam logic [GP_W-1:0]   GAIN_HALF   = GP_W'(1) << (GAIN_FRAC - 1);

    // ------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------

    // Shrinking deadband: values inside the band become zero, the rest move
    // toward zero by the band width (rescaled from Q1.15 by truncation).
    function automatic logic signed [SW-1:0] deadband(input logic signed [SW-1:0] v,
                                                      input logic [DEADBAND_W-1:0] w);
        logic [SW+6:0]        wide;
        logic signed [SW:0]   b;
        logic signed [SW:0]   vv;
        logic signed [SW:0]   r;
        wide = (SW+7)'(w) << (SW - 8);
        b    = $signed({2'b00, wide[SW+6:8]});
        vv   = (SW+1)'(v);
        if (vv > b)
        begin
            r = vv - b;
        end
        else if (vv < -b)
        begin
            r = vv + b;
        end
        else
        begin
            r = '0;
        end
        return r[SW-1:0];
    endfunction

    // Saturate a rounded product to the signed sample range.
    function automatic logic signed [SW-1:0] saturate(input logic signed [FR_W-1:0] v);
        logic signed [SW-1:0] r;
        if ((&v[FR_W-1:SW-1]) || !(|v[FR_W-1:SW-1]))
        begin
            r = v[SW-1:0];
        end
        else if (v[FR_W-1])
        begin
            r = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SW-1){1'b1}}};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------

    logic [DEADBAND_W-1:0] deadband_xy_reg;
    logic [DEADBAND_W-1:0] deadband_rot_reg;
    logic [GAIN_W-1:0]     field_speed_gain_reg;
    logic [GAIN_W-1:0]     slow_xy_gain_reg;
    logic [GAIN_W-1:0]     raw_rot_gain_reg;
    logic [GAIN_W-1:0]     slow_rot_gain_reg;
    logic [GAIN_W-1:0]     field_rot_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_xy_reg      <= RST_DEADBAND_XY;
            deadband_rot_reg     <= RST_DEADBAND_ROT;
            field_speed_gain_reg <= RST_FIELD_SPEED_GAIN;
            slow_xy_gain_reg     <= RST_SLOW_XY_GAIN;
            raw_rot_gain_reg     <= RST_RAW_ROT_GAIN;
            slow_rot_gain_reg    <= RST_SLOW_ROT_GAIN;
            field_rot_gain_reg   <= RST_FIELD_ROT_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEADBAND_XY:      deadband_xy_reg      <= cfg_wdata[DEADBAND_W-1:0];
                REG_DEADBAND_ROT:     deadband_rot_reg     <= cfg_wdata[DEADBAND_W-1:0];
                REG_FIELD_SPEED_GAIN: field_speed_gain_reg <= cfg_wdata;
                REG_SLOW_XY_GAIN:     slow_xy_gain_reg     <= cfg_wdata;
                REG_RAW_ROT_GAIN:     raw_rot_gain_reg     <= cfg_wdata;
                REG_SLOW_ROT_GAIN:    slow_rot_gain_reg    <= cfg_wdata;
                REG_FIELD_ROT_GAIN:   field_rot_gain_reg   <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------

    // A stage may load when it is empty or when the stage after it moves on,
    // so bubbles collapse while the receiver stalls.
    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE+1:1] stage_rdy;

    always_comb
    begin
        stage_rdy[NSTAGE+1] = m_tready;
        for (int k = NSTAGE; k >= 1; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    assign s_tready = stage_rdy[1];

    logic [NSTAGE:1] valid_next;

    always_comb
    begin
        valid_next[1] = stage_rdy[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= NSTAGE; k++)
        begin
            valid_next[k] = stage_rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load strobes for the payload registers of each stage.
    logic load1, load2, load3, load4, load5;

    assign load1 = s_tvalid && stage_rdy[1];
    assign load2 = valid_reg[1] && stage_rdy[2];
    assign load3 = valid_reg[2] && stage_rdy[3];
    assign load4 = valid_reg[3] && stage_rdy[4];
    assign load5 = valid_reg[4] && stage_rdy[5];

    // ------------------------------------------------------------------
    // Stage 1: unpack, deadband and sine table read
    // ------------------------------------------------------------------

    logic signed [SW-1:0]  in_x;
    logic signed [SW-1:0]  in_y;
    logic signed [SW-1:0]  in_twist;
    logic [HEADING_W-1:0]  in_heading;
    logic                  in_raw;
    logic                  in_slow;
    logic                  in_zero;
    logic [HEADING_W-1:0]  heading_rnd;
    logic [TB-1:0]         sin_idx;
    logic [TB-1:0]         cos_idx;

    assign in_x       = s_tdata[SW-1:0];
    assign in_y       = s_tdata[2*SW-1:SW];
    assign in_twist   = s_tdata[3*SW-1:2*SW];
    assign in_heading = s_tdata[3*SW+HEADING_W-1:3*SW];
    assign in_raw     = s_tdata[3*SW+HEADING_W];
    assign in_slow    = s_tdata[3*SW+HEADING_W+1];
    assign in_zero    = s_tdata[3*SW+HEADING_W+2];

    // Round the heading to the nearest table entry; the carry out wraps.
    assign heading_rnd = in_heading + HEADING_W'(HEAD_HALF);
    assign sin_idx     = heading_rnd[HEADING_W-1 -: TB];
    assign cos_idx     = sin_idx + QUARTER_IDX;

    // Full-turn sine table as a constant ROM, read twice per sample.
    logic signed [SINE_W-1:0] sine_rom [TABLE_SIZE];

    for (genvar g = 0; g < TABLE_SIZE; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g, TB);
    end

    logic signed [SW-1:0]     x1_reg, y1_reg;
    logic signed [SW-1:0]     dbx1_reg, dby1_reg, dbt1_reg;
    logic signed [SINE_W-1:0] sin1_reg, cos1_reg;
    logic                     raw1_reg, slow1_reg, zero1_reg;

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            x1_reg    <= in_x;
            y1_reg    <= in_y;
            dbx1_reg  <= deadband(in_x, deadband_xy_reg);
            dby1_reg  <= deadband(in_y, deadband_xy_reg);
            dbt1_reg  <= deadband(in_twist, deadband_rot_reg);
            sin1_reg  <= sine_rom[sin_idx];
            cos1_reg  <= sine_rom[cos_idx];
            raw1_reg  <= in_raw;
            slow1_reg <= in_slow;
            zero1_reg <= in_zero;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation products and gain products
    // ------------------------------------------------------------------

    logic [GAIN_W-1:0]        rot_gain_sel;
    logic signed [GAIN_W:0]   rot_gain_s;
    logic signed [GAIN_W:0]   slow_gain_s;

    always_comb
    begin
        priority if (raw1_reg)
        begin
            rot_gain_sel = raw_rot_gain_reg;
        end
        else if (slow1_reg)
        begin
            rot_gain_sel = slow_rot_gain_reg;
        end
        else
        begin
            rot_gain_sel = field_rot_gain_reg;
        end
    end

    assign rot_gain_s  = $signed({1'b0, rot_gain_sel});
    assign slow_gain_s = $signed({1'b0, slow_xy_gain_reg});

    logic signed [PROD_W-1:0] xc2_reg, ys2_reg, yc2_reg, xs2_reg;
    logic signed [GP_W-1:0]   gx2_reg, gy2_reg, gr2_reg;
    logic signed [SW-1:0]     dbx2_reg, dby2_reg;
    logic                     raw2_reg, slow2_reg, zero2_reg;

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            xc2_reg   <= PROD_W'(x1_reg) * PROD_W'(cos1_reg);
            ys2_reg   <= PROD_W'(y1_reg) * PROD_W'(sin1_reg);
            yc2_reg   <= PROD_W'(y1_reg) * PROD_W'(cos1_reg);
            xs2_reg   <= PROD_W'(x1_reg) * PROD_W'(sin1_reg);
            gx2_reg   <= GP_W'(dbx1_reg) * GP_W'(slow_gain_s);
            gy2_reg   <= GP_W'(dby1_reg) * GP_W'(slow_gain_s);
            gr2_reg   <= GP_W'(dbt1_reg) * GP_W'(rot_gain_s);
            dbx2_reg  <= dbx1_reg;
            dby2_reg  <= dby1_reg;
            raw2_reg  <= raw1_reg;
            slow2_reg <= slow1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotated vector, rounding of the Q4.12 gain products
    // ------------------------------------------------------------------

    logic [GP_W-1:0]        gx_rnd, gy_rnd, gr_rnd;
    logic signed [GR_W-1:0] gx_q, gy_q, gr_q;

    // Adding one half then dropping the fraction rounds halves upward.
    assign gx_rnd = gx2_reg + GAIN_HALF;
    assign gy_rnd = gy2_reg + GAIN_HALF;
    assign gr_rnd = gr2_reg + GAIN_HALF;
    assign gx_q   = $signed(gx_rnd[GP_W-1:GAIN_FRAC]);
    assign gy_q   = $signed(gy_rnd[GP_W-1:GAIN_FRAC]);
    assign gr_q   = $signed(gr_rnd[GP_W-1:GAIN_FRAC]);

    logic signed [PX_W-1:0] px3_reg, py3_reg;
    logic signed [SW-1:0]   sx3_reg, sy3_reg, dr3_reg;
    logic signed [SW-1:0]   dbx3_reg, dby3_reg;
    logic                   raw3_reg, slow3_reg, zero3_reg;

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            px3_reg   <= PX_W'(xc2_reg) + PX_W'(ys2_reg);
            py3_reg   <= PX_W'(yc2_reg) - PX_W'(xs2_reg);
            sx3_reg   <= saturate(FR_W'(gx_q));
            sy3_reg   <= saturate(FR_W'(gy_q));
            dr3_reg   <= saturate(FR_W'(gr_q));
            dbx3_reg  <= dbx2_reg;
            dby3_reg  <= dby2_reg;
            raw3_reg  <= raw2_reg;
            slow3_reg <= slow2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: field gain as two partial products per axis
    // ------------------------------------------------------------------

    logic signed [GAIN_W:0] field_gain_s;
    logic signed [HI_W-1:0] px_hi, py_hi;
    logic [LO_W-1:0]        px_lo, py_lo;

    assign field_gain_s = $signed({1'b0, field_speed_gain_reg});
    assign px_hi        = px3_reg[PX_W-1:LO_W];
    assign py_hi        = py3_reg[PX_W-1:LO_W];
    assign px_lo        = px3_reg[LO_W-1:0];
    assign py_lo        = py3_reg[LO_W-1:0];

    logic [PL_W-1:0]        pxl4_reg, pyl4_reg;
    logic signed [PH_W-1:0] pxh4_reg, pyh4_reg;
    logic signed [SW-1:0]   nfx4_reg, nfy4_reg, dr4_reg;
    logic                   field4_reg, zero4_reg;

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            // The rounding half is folded into the low partial product.
            pxl4_reg   <= PL_W'(px_lo) * PL_W'(field_speed_gain_reg) + FIELD_HALF;
            pyl4_reg   <= PL_W'(py_lo) * PL_W'(field_speed_gain_reg) + FIELD_HALF;
            pxh4_reg   <= PH_W'(px_hi) * PH_W'(field_gain_s);
            pyh4_reg   <= PH_W'(py_hi) * PH_W'(field_gain_s);
            nfx4_reg   <= raw3_reg ? dbx3_reg : sx3_reg;
            nfy4_reg   <= raw3_reg ? dby3_reg : sy3_reg;
            dr4_reg    <= dr3_reg;
            field4_reg <= !raw3_reg && !slow3_reg;
            zero4_reg  <= zero3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine, round, saturate and select the mode result
    // ------------------------------------------------------------------

    logic [FULL_W-1:0]      fx_sum, fy_sum;
    logic signed [FR_W-1:0] fx_q, fy_q;

    assign fx_sum = (FULL_W'(pxh4_reg) << LO_W) + FULL_W'(pxl4_reg);
    assign fy_sum = (FULL_W'(pyh4_reg) << LO_W) + FULL_W'(pyl4_reg);
    assign fx_q   = $signed(fx_sum[FULL_W-1:FIELD_SHIFT]);
    assign fy_q   = $signed(fy_sum[FULL_W-1:FIELD_SHIFT]);

    logic signed [SW-1:0] drive_x5_reg, drive_y5_reg, drive_rot5_reg;
    logic                 zero5_reg;

    always_ff @(posedge clk)
    begin
        if (load5)
        begin
            drive_x5_reg   <= field4_reg ? saturate(fx_q) : nfx4_reg;
            drive_y5_reg   <= field4_reg ? saturate(fy_q) : nfy4_reg;
            drive_rot5_reg <= dr4_reg;
            zero5_reg      <= zero4_reg;
        end
    end

    assign m_tvalid = valid_reg[NSTAGE];
    assign m_tdata  = OUT_W'({zero5_reg, drive_rot5_reg, drive_y5_reg, drive_x5_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A sample in the first stage moves on when the second stage can take it.
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && stage_rdy[2] |=> valid_reg[2])
        else $error("sample lost between stage 1 and stage 2");

    // The input side only stalls when every stage is full and the output waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg) && m_tvalid && !m_tready)
        else $error("input stalled while the pipeline still had room");

    // A non-zero deadbanded axis keeps the sign of the stick value.
    a_deadband_sign: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && (dbx1_reg != '0) |-> dbx1_reg[SW-1] == x1_reg[SW-1])
        else $error("deadband changed the sign of the x axis");

    // A field-mode sample leaves stage 3 flagged for the rotated result.
    a_field_flag: assert property (@(posedge clk) disable iff (!rst_n)
        load4 && !raw3_reg && !slow3_reg |=> field4_reg)
        else $error("field mode flag lost in stage 4");

endmodule
